@@ sv/arf_pkg.sv @@
// Package for the auto rate fallback block: register map, field widths and
// reset values. No dependencies.
package arf_pkg;

  localparam int unsigned McsW       = 4;
  localparam int unsigned AttemptW   = 4;
  localparam int unsigned SuccessW   = 16;
  localparam int unsigned TicksW     = 20;
  localparam int unsigned InitThrW   = 10;
  localparam int unsigned ThrW       = 11;
  localparam int unsigned ApbAddrW   = 5;
  localparam int unsigned ApbDataW   = 32;

  // Register reset values
  localparam logic [TicksW-1:0]   RecoveryTicksRst = 20'd1000;
  localparam logic                BackoffEnableRst = 1'b1;
  localparam logic [InitThrW-1:0] InitThresholdRst = 10'd10;
  localparam logic [InitThrW-1:0] MaxThresholdRst  = 10'd50;
  localparam logic [McsW-1:0]     InitMcsRst       = 4'd0;
  localparam logic [McsW-1:0]     MaxMcsRst        = 4'd7;

  // Attempt numbers that force a fall
  localparam logic [AttemptW-1:0] ProbeFailAttempt = 4'd2;
  localparam logic [AttemptW-1:0] ForceFallAttempt = 4'd3;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_RECOVERY_TICKS    = 3'd0,
    REG_BACKOFF_ENABLE    = 3'd1,
    REG_INITIAL_THRESHOLD = 3'd2,
    REG_MAX_THRESHOLD     = 3'd3,
    REG_INITIAL_MCS       = 3'd4,
    REG_MAX_MCS           = 3'd5
  } arf_reg_e;

  // Input operation codes
  typedef enum logic {
    OP_TICK     = 1'b0,
    OP_TRANSMIT = 1'b1
  } arf_op_e;

endpackage

@@ sv/arf_rate_adaptation_top.sv @@
// Auto rate fallback with adaptive threshold backoff, one link.
// Depends on arf_pkg for the register map, widths and reset values.
//
// Usage:
//  - Input channel (in_valid_i / in_ready_o) carries one item per handshake:
//    a timer tick (operation 0) or a transmit decision (operation 1) with the
//    frame's attempt number and the current success count.
//  - Output channel (out_valid_o / out_ready_i) returns exactly one item per
//    input item: the MCS now current, a flag to clear the success counter
//    when the MCS moved, and a flag marking the next frame as a probe.
//  - The decision and the state commit happen at the accepting edge and the
//    result sits in the output register from the next cycle. Throughput is
//    one item per cycle while the receiver keeps up; the decision is a few
//    compares, an increment and a shift on the state registers.
//  - When the receiver stalls, the output register holds its item and
//    in_ready_o drops only while that item is still unclaimed; an item is
//    taken in the same cycle the held one leaves.
//  - Reset loads the register defaults, sets the MCS to the initial MCS and
//    the threshold to the initial threshold, and stops the recovery timer.
//  - The APB port writes the six registers at 4*index; writing the initial
//    MCS also reloads the current MCS. Write only while the block is idle.
module arf_rate_adaptation_top
  import arf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // APB configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ApbAddrW-1:0]  paddr,
  input  logic [ApbDataW-1:0]  pwdata,
  output logic [ApbDataW-1:0]  prdata,
  output logic                 pready,
  // Input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 operation_i,
  input  logic [AttemptW-1:0]  attempt_number_i,
  input  logic [SuccessW-1:0]  success_count_i,
  // Result items
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [McsW-1:0]      mcs_o,
  output logic                 clear_success_count_o,
  output logic                 is_probe_o
);

  // Configuration registers
  logic [TicksW-1:0]   recovery_ticks_q;
  logic                backoff_enable_q;
  logic [InitThrW-1:0] initial_threshold_q;
  logic [InitThrW-1:0] max_threshold_q;
  logic [McsW-1:0]     initial_mcs_q;
  logic [McsW-1:0]     max_mcs_q;

  // Link state
  logic [McsW-1:0]   current_mcs_q, current_mcs_d;
  logic              probe_pending_q, probe_pending_d;
  logic              timeout_flag_q, timeout_flag_d;
  logic [ThrW-1:0]   success_threshold_q, success_threshold_d;
  logic [TicksW-1:0] timer_count_q, timer_count_d;
  logic              timer_running_q, timer_running_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  logic [McsW-1:0] mcs_q, mcs_d;
  logic            clear_q, clear_d;
  logic            probe_q, probe_d;

  logic            in_accept;
  logic            cfg_write;
  arf_reg_e        cfg_reg;

  // Decision terms
  logic [McsW-1:0]   mcs_up;
  logic [McsW-1:0]   mcs_down;
  logic [McsW-1:0]   pick_mcs;
  logic              mcs_changed;
  logic              fall;
  logic [TicksW-1:0] tick_count;
  logic [ThrW-1:0]   half_threshold;
  logic [ThrW-1:0]   init_thr_ext;

  // The output register frees up when empty or when its item leaves now
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign mcs_o                 = mcs_q;
  assign clear_success_count_o = clear_q;
  assign is_probe_o            = probe_q;

  // ------------------------------------------------------------------
  // APB: pready is tied high, so a write lands in its access cycle
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_reg   = arf_reg_e'(paddr[ApbAddrW-1:2]);

  always_comb begin
    prdata = '0;
    unique case (cfg_reg)
      REG_RECOVERY_TICKS:    prdata = ApbDataW'(recovery_ticks_q);
      REG_BACKOFF_ENABLE:    prdata = ApbDataW'(backoff_enable_q);
      REG_INITIAL_THRESHOLD: prdata = ApbDataW'(initial_threshold_q);
      REG_MAX_THRESHOLD:     prdata = ApbDataW'(max_threshold_q);
      REG_INITIAL_MCS:       prdata = ApbDataW'(initial_mcs_q);
      REG_MAX_MCS:           prdata = ApbDataW'(max_mcs_q);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recovery_ticks_q    <= RecoveryTicksRst;
      backoff_enable_q    <= BackoffEnableRst;
      initial_threshold_q <= InitThresholdRst;
      max_threshold_q     <= MaxThresholdRst;
      initial_mcs_q       <= InitMcsRst;
      max_mcs_q           <= MaxMcsRst;
    end else if (cfg_write) begin
      unique case (cfg_reg)
        REG_RECOVERY_TICKS:    recovery_ticks_q    <= pwdata[TicksW-1:0];
        REG_BACKOFF_ENABLE:    backoff_enable_q    <= pwdata[0];
        REG_INITIAL_THRESHOLD: initial_threshold_q <= pwdata[InitThrW-1:0];
        REG_MAX_THRESHOLD:     max_threshold_q     <= pwdata[InitThrW-1:0];
        REG_INITIAL_MCS:       initial_mcs_q       <= pwdata[McsW-1:0];
        REG_MAX_MCS:           max_mcs_q           <= pwdata[McsW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Decision: pick the MCS for a transmit item
  // ------------------------------------------------------------------
  assign mcs_up   = (current_mcs_q < max_mcs_q) ? current_mcs_q + McsW'(1) : current_mcs_q;
  assign mcs_down = (current_mcs_q != '0) ? current_mcs_q - McsW'(1) : current_mcs_q;
  assign fall     = (probe_pending_q && attempt_number_i == ProbeFailAttempt)
                    || attempt_number_i >= ForceFallAttempt;

  always_comb begin
    priority if (timeout_flag_q) begin
      pick_mcs = mcs_up;
    end else if (fall) begin
      pick_mcs = mcs_down;
    end else if (SuccessW'(success_threshold_q) == success_count_i) begin
      pick_mcs = mcs_up;
    end else begin
      pick_mcs = current_mcs_q;
    end
  end

  assign mcs_changed    = pick_mcs != current_mcs_q;
  assign tick_count     = timer_count_q + TicksW'(1);
  assign init_thr_ext   = ThrW'(initial_threshold_q);
  assign half_threshold = success_threshold_q >> 1;

  // ------------------------------------------------------------------
  // Next state and result
  // ------------------------------------------------------------------
  always_comb begin
    current_mcs_d       = current_mcs_q;
    probe_pending_d     = probe_pending_q;
    timeout_flag_d      = timeout_flag_q;
    success_threshold_d = success_threshold_q;
    timer_count_d       = timer_count_q;
    timer_running_d     = timer_running_q;
    out_valid_d         = out_valid_q && !out_ready_i;
    mcs_d               = mcs_q;
    clear_d             = clear_q;
    probe_d             = probe_q;

    if (in_accept) begin
      out_valid_d = 1'b1;
      if (arf_op_e'(operation_i) == OP_TICK) begin
        // Advance the recovery timer; fire and stop at the limit
        if (timer_running_q) begin
          timer_count_d = tick_count;
          if (tick_count >= recovery_ticks_q) begin
            timeout_flag_d  = 1'b1;
            timer_running_d = 1'b0;
          end
        end
        mcs_d   = current_mcs_q;
        clear_d = 1'b0;
        probe_d = 1'b0;
      end else begin
        timeout_flag_d = 1'b0;
        clear_d        = mcs_changed;
        probe_d        = 1'b0;
        mcs_d          = pick_mcs;
        if (!mcs_changed) begin
          probe_pending_d = 1'b0;
        end else if (pick_mcs < current_mcs_q) begin
          // Fall: restart the timer, adapt the threshold
          timer_running_d = 1'b1;
          timer_count_d   = '0;
          if (probe_pending_q) begin
            probe_pending_d = 1'b0;
            if (backoff_enable_q && success_threshold_q < ThrW'(max_threshold_q)) begin
              success_threshold_d = {success_threshold_q[ThrW-2:0], 1'b0};
            end
          end else if (backoff_enable_q) begin
            success_threshold_d = (half_threshold < init_thr_ext) ? init_thr_ext
                                                                  : half_threshold;
          end
          current_mcs_d = pick_mcs;
        end else begin
          // Rise: cancel the timer, next frame is a probe
          timer_running_d = 1'b0;
          timer_count_d   = '0;
          probe_pending_d = 1'b1;
          probe_d         = 1'b1;
          current_mcs_d   = pick_mcs;
        end
      end
    end

    // A write of the initial MCS reloads the current MCS
    if (cfg_write && cfg_reg == REG_INITIAL_MCS) begin
      current_mcs_d = pwdata[McsW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_mcs_q       <= InitMcsRst;
      probe_pending_q     <= 1'b0;
      timeout_flag_q      <= 1'b0;
      success_threshold_q <= ThrW'(InitThresholdRst);
      timer_count_q       <= '0;
      timer_running_q     <= 1'b0;
      out_valid_q         <= 1'b0;
    end else begin
      current_mcs_q       <= current_mcs_d;
      probe_pending_q     <= probe_pending_d;
      timeout_flag_q      <= timeout_flag_d;
      success_threshold_q <= success_threshold_d;
      timer_count_q       <= timer_count_d;
      timer_running_q     <= timer_running_d;
      out_valid_q         <= out_valid_d;
    end
  end

  // Payload of the output register
  always_ff @(posedge clk_i) begin
    mcs_q   <= mcs_d;
    clear_q <= clear_d;
    probe_q <= probe_d;
  end

  // ------------------------------------------------------------------
  // Assertions
  // ------------------------------------------------------------------
  // A probe is always a change of MCS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && probe_q |-> clear_q)
    else $error("probe reported without an MCS change");

  // The timer never runs once it has fired
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(timer_running_q && timeout_flag_q))
    else $error("recovery timer running with timeout flag set");

  // An accepted transmit that moves the MCS shows up as a clear next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && operation_i && mcs_changed |=> out_valid_q && clear_q && mcs_q == current_mcs_q)
    else $error("MCS change not reported");

  // A tick never changes the MCS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && !operation_i && !(cfg_write && cfg_reg == REG_INITIAL_MCS)
    |=> $stable(current_mcs_q) && !clear_q)
    else $error("timer tick altered the MCS");

endmodule
